/* design/assert_macros.svh */
// Assertion macros for the port-level checker.
// Each macro takes a label, the clock, the active-low reset, a trigger and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequence must hold in the same cycle as the trigger.
`define T1CS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("t1cs check failed: same-cycle rule");

// Consequence must hold in the cycle after the trigger.
`define T1CS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("t1cs check failed: next-cycle rule");

`endif

/* design/t1cs_pkg.sv */
`timescale 1ns / 1ps
// Types and constants of the charstring number encoder.
// No dependencies; the divider, front, queue, back and top import this package.
package t1cs_pkg;

  localparam int BIG_W     = 32;  // scaled value and encoded integer width
  localparam int ACC_W     = 48;  // exact and emitted position accumulators
  localparam int PREC_W    = 7;   // precision register width
  localparam int PROD_W    = ACC_W + PREC_W + 1;  // signed product width
  localparam int MAX_BYTES = 8;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int IDX_W     = $clog2(MAX_BYTES);
  localparam int MID_W     = 10;  // two-byte form payload

  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_CYCLES    = BIG_W / DIV_STEP_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

  // Queue depth must be a power of two so the pointers wrap naturally.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register map
  localparam int REG_IDX_W = 1;
  localparam int PADDR_W   = REG_IDX_W + 2;
  localparam int PDATA_W   = 32;
  localparam logic [REG_IDX_W-1:0] REG_PRECISION = '0;

  localparam logic [PREC_W-1:0] PREC_DEFAULT = 7'd5;
  localparam logic [PREC_W-1:0] PREC_MAX     = 7'd107;

  // Charstring encoding constants
  localparam logic [7:0]        ESC_BYTE    = 8'd12;
  localparam logic [7:0]        DIV_SUB     = 8'd12;
  localparam logic [PREC_W-1:0] ESC_DELTA   = 7'd32;
  localparam logic [7:0]        BYTE_BIAS   = 8'd139;
  localparam logic [7:0]        POS_BASE    = 8'd247;
  localparam logic [7:0]        NEG_BASE    = 8'd251;
  localparam logic [7:0]        LONG_PREFIX = 8'd255;
  localparam int                SHORT_LIM   = 107;
  localparam int                MID_LIM     = 1131;
  localparam int                MID_OFF     = 108;

  typedef enum logic {
    OP_NUMBER  = 1'b0,
    OP_COMMAND = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    KIND_PLAIN = 3'd0,
    KIND_REL_X = 3'd1,
    KIND_REL_Y = 3'd2,
    KIND_ABS_X = 3'd3,
    KIND_ABS_Y = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_RND,
    F_BIG,
    F_EMU,
    F_DIV,
    F_PUSH
  } front_state_e;

  // One item's worth of output bytes, built by the front, drained by the back.
  typedef struct packed {
    logic [CNT_W-1:0]               cnt;
    logic [MAX_BYTES-1:0][7:0]      bytes;
  } desc_t;

  typedef struct packed {
    logic  push;
    desc_t desc;
  } q_wr_t;

  typedef struct packed {
    logic  empty;
    desc_t desc;
  } q_rd_t;

  typedef struct packed {
    logic              start;
    logic [BIG_W-1:0]  dividend;
    logic [PREC_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [BIG_W-1:0] quot;
    logic             rem_zero;
  } div_res_t;

endpackage

/* design/t1cs_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input items and output bytes.
// Plain widths only; no package dependency.
interface t1cs_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] value;
  logic [2:0]         kind;
  logic [6:0]         command;

  modport source (output valid, op, value, kind, command, input ready);
  modport sink   (input valid, op, value, kind, command, output ready);
endinterface

interface t1cs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

/* design/t1cs_div.sv */
`timescale 1ns / 1ps
// Iterative unsigned divider, four quotient bits per cycle.
// Depends on t1cs_pkg.
module t1cs_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  t1cs_pkg::div_req_t  req_i,
  output t1cs_pkg::div_res_t  res_o
);
  import t1cs_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [BIG_W-1:0]     dq_q, dq_d;
  logic [PREC_W-1:0]    rem_q, rem_d;
  logic [PREC_W-1:0]    dvs_q;
  logic [PREC_W:0]      r8;
  logic                 last_step;

  assign last_step = busy_q && (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1));

  // Restoring steps; remainder stays below the divisor, so it fits PREC_W bits.
  always_comb begin
    dq_d  = dq_q;
    rem_d = rem_q;
    r8    = '0;
    for (int k = 0; k < DIV_STEP_BITS; k++) begin
      r8   = {rem_d, dq_d[BIG_W-1]};
      dq_d = {dq_d[BIG_W-2:0], 1'b0};
      if (r8 >= {1'b0, dvs_q}) begin
        r8       = r8 - {1'b0, dvs_q};
        dq_d[0]  = 1'b1;
      end
      rem_d = r8[PREC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last_step;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dq_q  <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign res_o.done     = done_q;
  assign res_o.quot     = dq_q;
  assign res_o.rem_zero = (rem_q == '0);

endmodule

/* design/t1cs_front.sv */
`timescale 1ns / 1ps
// Front end: accepts items, tracks positions, scales and rounds, builds byte descriptors.
// Depends on t1cs_pkg and t1cs_in_if; drives the divider and the descriptor queue.
module t1cs_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  t1cs_in_if.sink                   in_i,
  input  logic [t1cs_pkg::PREC_W-1:0] prec_i,
  output t1cs_pkg::div_req_t        div_req_o,
  input  t1cs_pkg::div_res_t        div_res_i,
  output t1cs_pkg::q_wr_t           q_wr_o,
  input  logic                      q_full_i
);
  import t1cs_pkg::*;

  localparam int TW = (PROD_W > FRAC_BITS + BIG_W) ? PROD_W : FRAC_BITS + BIG_W;
  localparam logic signed [TW-1:0] HALF = {{(TW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  front_state_e state_q, state_d;

  logic                     acc;
  logic                     in_cmd, in_rel, in_trk, in_axis;
  logic                     op_q, rel_q, trk_q, axis_q, frac_nz_q;
  logic [PREC_W-1:0]        cmd_q;
  logic signed [ACC_W-1:0]  exact_x_q, exact_y_q, em_x_q, em_y_q, mul_a_q;
  logic signed [ACC_W-1:0]  val48, exact_sel, exact_new, em_sel, em_new;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PREC_W:0]   p_s;
  logic signed [TW-1:0]     t_sum;
  logic [BIG_W-1:0]         rnd_q, big_q, val_q, big_mag, signed_quot, mag;
  logic signed [BIG_W-1:0]  val_s;
  logic [MID_W-1:0]         mid_a;
  logic                     short_f, mid_f;
  logic [CNT_W-1:0]         nn;
  logic [MAX_BYTES-1:0][7:0] nb;
  desc_t                    desc;

  assign acc    = in_i.valid && in_i.ready;
  assign in_cmd = (op_e'(in_i.op) == OP_COMMAND);

  // Decode the coordinate kind; unused codes behave as plain.
  always_comb begin
    in_rel  = 1'b0;
    in_trk  = 1'b0;
    in_axis = 1'b0;
    unique case (kind_e'(in_i.kind))
      KIND_REL_X: begin
        in_rel = 1'b1;
        in_trk = 1'b1;
      end
      KIND_REL_Y: begin
        in_rel  = 1'b1;
        in_trk  = 1'b1;
        in_axis = 1'b1;
      end
      KIND_ABS_X: begin
        in_trk = 1'b1;
      end
      KIND_ABS_Y: begin
        in_trk  = 1'b1;
        in_axis = 1'b1;
      end
      default: begin
        in_rel = 1'b0;
      end
    endcase
  end

  assign val48     = ACC_W'(in_i.value);
  assign exact_sel = in_axis ? exact_y_q : exact_x_q;
  assign exact_new = in_rel ? exact_sel + val48 : val48;
  assign em_sel    = axis_q ? em_y_q : em_x_q;
  assign em_new    = rel_q ? em_sel + ACC_W'($signed(big_q)) : ACC_W'($signed(big_q));
  assign p_s       = {1'b0, prec_i};
  assign t_sum     = TW'(prod_q) + HALF;
  assign big_mag   = big_q[BIG_W-1] ? -big_q : big_q;
  assign signed_quot = big_q[BIG_W-1] ? -div_res_i.quot : div_res_i.quot;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (acc) begin
          state_d = in_cmd ? F_PUSH : F_MUL;
        end
      end
      F_MUL: state_d = F_RND;
      F_RND: state_d = F_BIG;
      F_BIG: state_d = F_EMU;
      F_EMU: state_d = F_DIV;
      F_DIV: begin
        if (div_res_i.done) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    in_i.ready         = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = big_mag;
    div_req_o.divisor  = prec_i;
    q_wr_o.push        = 1'b0;
    q_wr_o.desc        = desc;
    unique case (state_q)
      F_IDLE: in_i.ready      = 1'b1;
      F_EMU:  div_req_o.start = 1'b1;
      F_PUSH: q_wr_o.push     = !q_full_i;
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      exact_x_q <= '0;
      exact_y_q <= '0;
      em_x_q    <= '0;
      em_y_q    <= '0;
    end else begin
      state_q <= state_d;
      if (acc && !in_cmd && in_trk) begin
        if (in_axis) begin
          exact_y_q <= exact_new;
        end else begin
          exact_x_q <= exact_new;
        end
      end
      if (state_q == F_EMU && trk_q) begin
        if (axis_q) begin
          em_y_q <= em_new;
        end else begin
          em_x_q <= em_new;
        end
      end
    end
  end

  // Datapath registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (acc) begin
      op_q    <= in_i.op;
      cmd_q   <= in_i.command;
      rel_q   <= in_rel;
      trk_q   <= in_trk;
      axis_q  <= in_axis;
      mul_a_q <= exact_new;
    end
    if (state_q == F_MUL) begin
      prod_q <= mul_a_q * p_s;
    end
    if (state_q == F_RND) begin
      rnd_q <= t_sum[FRAC_BITS +: BIG_W];
    end
    if (state_q == F_BIG) begin
      big_q <= rel_q ? rnd_q - em_sel[BIG_W-1:0] : rnd_q;
    end
    if (state_q == F_DIV && div_res_i.done) begin
      frac_nz_q <= !div_res_i.rem_zero;
      val_q     <= div_res_i.rem_zero ? signed_quot : big_q;
    end
  end

  // Integer forms: one, two or five bytes
  assign val_s   = $signed(val_q);
  assign mag     = val_q[BIG_W-1] ? -val_q : val_q;
  assign mid_a   = MID_W'(mag - BIG_W'(MID_OFF));
  assign short_f = (val_s >= -SHORT_LIM) && (val_s <= SHORT_LIM);
  assign mid_f   = (val_s >= -MID_LIM) && (val_s <= MID_LIM);

  always_comb begin
    nb = '0;
    if (short_f) begin
      nn    = CNT_W'(1);
      nb[0] = val_q[7:0] + BYTE_BIAS;
    end else if (mid_f) begin
      nn    = CNT_W'(2);
      nb[0] = (val_q[BIG_W-1] ? NEG_BASE : POS_BASE) + {6'b0, mid_a[9:8]};
      nb[1] = mid_a[7:0];
    end else begin
      nn    = CNT_W'(5);
      nb[0] = LONG_PREFIX;
      nb[1] = val_q[31:24];
      nb[2] = val_q[23:16];
      nb[3] = val_q[15:8];
      nb[4] = val_q[7:0];
    end
  end

  // Descriptor: a command, or the integer followed by precision and div when inexact
  always_comb begin
    desc = '0;
    if (op_e'(op_q) == OP_COMMAND) begin
      if (cmd_q >= ESC_DELTA) begin
        desc.cnt      = CNT_W'(2);
        desc.bytes[0] = ESC_BYTE;
        desc.bytes[1] = {1'b0, cmd_q - ESC_DELTA};
      end else begin
        desc.cnt      = CNT_W'(1);
        desc.bytes[0] = {1'b0, cmd_q};
      end
    end else begin
      desc.cnt = frac_nz_q ? nn + CNT_W'(3) : nn;
      for (int i = 0; i < MAX_BYTES; i++) begin
        if (CNT_W'(i) < nn) begin
          desc.bytes[i] = nb[i];
        end else if (frac_nz_q && CNT_W'(i) == nn) begin
          desc.bytes[i] = {1'b0, prec_i} + BYTE_BIAS;
        end else if (frac_nz_q && CNT_W'(i) < nn + CNT_W'(3)) begin
          desc.bytes[i] = (CNT_W'(i) == nn + CNT_W'(1)) ? ESC_BYTE : DIV_SUB;
        end
      end
    end
  end

endmodule

/* design/t1cs_fifo.sv */
`timescale 1ns / 1ps
// Short descriptor queue between the front and the back.
// Depends on t1cs_pkg.
module t1cs_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  t1cs_pkg::q_wr_t  wr_i,
  input  logic             pop_i,
  output t1cs_pkg::q_rd_t  rd_o,
  output logic             full_o
);
  import t1cs_pkg::*;

  desc_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign rd_o.empty = (cnt_q == '0);
  assign rd_o.desc  = mem_q[rd_ptr_q];
  assign push       = wr_i.push && !full_o;
  assign pop        = pop_i && !rd_o.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_i.desc;
    end
  end

endmodule

/* design/t1cs_back.sv */
`timescale 1ns / 1ps
// Back end: drains descriptors and sends their bytes one beat at a time.
// Depends on t1cs_pkg and t1cs_out_if.
module t1cs_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  t1cs_pkg::q_rd_t  rd_i,
  output logic             pop_o,
  t1cs_out_if.source       out_o
);
  import t1cs_pkg::*;

  desc_t            desc_q;
  logic [IDX_W-1:0] idx_q;
  logic             busy_q;
  logic             take, at_last;

  assign at_last      = ({1'b0, idx_q} == desc_q.cnt - 1'b1);
  assign take         = out_o.valid && out_o.ready;
  assign pop_o        = (!busy_q || (take && at_last)) && !rd_i.empty;
  assign out_o.valid  = busy_q;
  assign out_o.out_byte = desc_q.bytes[idx_q];
  assign out_o.last   = at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (take) begin
      if (at_last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      desc_q <= rd_i.desc;
    end
  end

endmodule

/* design/type1_charstring_number_encoder_top.sv */
`timescale 1ns / 1ps
// Type 1 charstring number encoder, top level.
// Depends on t1cs_pkg, t1cs_if, t1cs_front, t1cs_div, t1cs_fifo and t1cs_back.
//
// Usage:
//   in_i  : one beat per item; op selects a number (value, kind) or a command code.
//   out_o : charstring bytes, one per beat; last marks the final byte of an item.
//   APB   : one register, precision, byte address 0; low 7 bits kept, read back.
//   A number passes the front states in order: a multiply by precision, a
//   rounding add, a subtract of the emitted position, a state that updates the
//   emitted position and starts the divider, the divider (8 steps at four
//   quotient bits a cycle, then a registered done hands over the result), a
//   queue write and the return to idle. A command goes from idle to the write.
//   The back sends an item's bytes one per cycle while the receiver is ready,
//   up to 8.
//   Front and back overlap through a two-entry descriptor queue, so the back
//   drains one item while the front works on the next.
//   Reset: precision 5, all positions zero, queue empty, no output beat.
//   If the receiver stalls, the current byte holds; once the queue is full
//   the front stops taking new items until space frees up.
//   Write precision only while idle; a stored 0 or a value above 107 acts as 5.
module type1_charstring_number_encoder_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  t1cs_in_if.sink                           in_i,
  t1cs_out_if.source                        out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [t1cs_pkg::PADDR_W-1:0]      paddr,
  input  logic [t1cs_pkg::PDATA_W-1:0]      pwdata,
  output logic [t1cs_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);
  import t1cs_pkg::*;

  logic [PREC_W-1:0]    prec_q, prec_eff;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  div_req_t             div_req;
  div_res_t             div_res;
  q_wr_t                q_wr;
  q_rd_t                q_rd;
  logic                 q_full, q_pop;

  // Register file: word index sits above the byte offset
  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_PRECISION);
  assign prdata  = (reg_idx == REG_PRECISION) ? PDATA_W'(prec_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prec_q <= PREC_DEFAULT;
    end else if (cfg_wr) begin
      prec_q <= pwdata[PREC_W-1:0];
    end
  end

  // Fall back to the default for a precision outside 1..107
  assign prec_eff = (prec_q != '0 && prec_q <= PREC_MAX) ? prec_q : PREC_DEFAULT;

  t1cs_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .prec_i    (prec_eff),
    .div_req_o (div_req),
    .div_res_i (div_res),
    .q_wr_o    (q_wr),
    .q_full_i  (q_full)
  );

  t1cs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  t1cs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .pop_i  (q_pop),
    .rd_o   (q_rd),
    .full_o (q_full)
  );

  t1cs_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (q_rd),
    .pop_o  (q_pop),
    .out_o  (out_o)
  );

endmodule

/* design/t1cs_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the encoder top, attached by bind.
// Depends on assert_macros.svh and type1_charstring_number_encoder_top.
`include "assert_macros.svh"

module t1cs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);

  // The front works on one item at a time: no beat right after a taken one.
  `T1CS_ASSERT_NEXT(a_in_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // Bytes of one item go out without a gap once started.
  `T1CS_ASSERT_NEXT(a_burst_unbroken, clk_i, rst_ni, out_valid_i && out_ready_i && !out_last_i, out_valid_i)

  // A stalled output beat holds.
  `T1CS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_byte_i) && $stable(out_last_i))

endmodule

bind type1_charstring_number_encoder_top t1cs_checker u_t1cs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_last_i  (out_o.last)
);

/* tb/t1cs_encoder_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the charstring number encoder: predicts the bytes of every input beat,
// compares them with the output channel and checks register read-back.
// Depends on t1cs_pkg and the channel interfaces of t1cs_if.
module t1cs_encoder_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  t1cs_in_if                           items_i,
  t1cs_out_if                          bytes_i,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [t1cs_pkg::PADDR_W-1:0] paddr,
  input  logic [t1cs_pkg::PDATA_W-1:0] pwdata,
  input  logic [t1cs_pkg::PDATA_W-1:0] prdata,
  input  logic                         pready,
  output int                           errors_o,
  output int                           pending_o
);
  import t1cs_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cs_byte_t;

  cs_byte_t                charstring_q[$];
  logic signed [ACC_W-1:0] exact_x, exact_y, shown_x, shown_y;
  logic [PREC_W-1:0]       precision;
  int                      fail_count = 0;

  assign errors_o = fail_count;

  // floor((q * p + half) / 2^FRAC_BITS)
  function automatic longint round_half_up(longint q, longint p);
    return (q * p + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic void encode_item(logic op, logic signed [31:0] value, logic [2:0] kind,
                                      logic [6:0] command);
    logic [7:0]              cs[$];
    logic signed [BIG_W-1:0] big32;
    logic [31:0]             word;
    longint                  p, wide, big, val, magn;
    if (op == OP_COMMAND) begin
      if (command >= ESC_DELTA) begin
        cs.push_back(ESC_BYTE);
        cs.push_back(8'(command - ESC_DELTA));
      end else begin
        cs.push_back(8'(command));
      end
    end else begin
      p = (precision >= 1 && precision <= PREC_MAX) ? longint'(precision)
                                                     : longint'(PREC_DEFAULT);
      case (kind)
        KIND_REL_X: begin
          exact_x = exact_x + ACC_W'(value);
          wide    = round_half_up(exact_x, p) - shown_x;
        end
        KIND_REL_Y: begin
          exact_y = exact_y + ACC_W'(value);
          wide    = round_half_up(exact_y, p) - shown_y;
        end
        KIND_ABS_X: begin
          exact_x = ACC_W'(value);
          wide    = round_half_up(value, p);
        end
        KIND_ABS_Y: begin
          exact_y = ACC_W'(value);
          wide    = round_half_up(value, p);
        end
        default: wide = round_half_up(value, p);
      endcase
      big32 = wide[BIG_W-1:0];
      big   = big32;
      val   = (big % p == 0) ? big / p : big;

      if (val >= -SHORT_LIM && val <= SHORT_LIM) begin
        cs.push_back(8'(val + BYTE_BIAS));
      end else if (val >= -MID_LIM && val <= MID_LIM) begin
        magn = ((val < 0) ? -val : val) - MID_OFF;
        cs.push_back(8'(((val < 0) ? NEG_BASE : POS_BASE) + magn / 256));
        cs.push_back(8'(magn % 256));
      end else begin
        word = val[31:0];
        cs.push_back(LONG_PREFIX);
        cs.push_back(word[31:24]);
        cs.push_back(word[23:16]);
        cs.push_back(word[15:8]);
        cs.push_back(word[7:0]);
      end
      // not a whole number: follow with precision and the div operator
      if (big % p != 0) begin
        cs.push_back(8'(p + BYTE_BIAS));
        cs.push_back(ESC_BYTE);
        cs.push_back(DIV_SUB);
      end

      case (kind)
        KIND_REL_X: shown_x = shown_x + ACC_W'(big);
        KIND_REL_Y: shown_y = shown_y + ACC_W'(big);
        KIND_ABS_X: shown_x = ACC_W'(big);
        KIND_ABS_Y: shown_y = ACC_W'(big);
        default: ;
      endcase
    end
    foreach (cs[i]) charstring_q.push_back(cs_byte_t'{data: cs[i], last: (i == cs.size() - 1)});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cs_byte_t want;
    if (!rst_ni) begin
      charstring_q.delete();
      exact_x   = '0;
      exact_y   = '0;
      shown_x   = '0;
      shown_y   = '0;
      precision = PREC_DEFAULT;
      pending_o <= 0;
    end else begin
      if (bytes_i.valid && bytes_i.ready) begin
        if (charstring_q.size() == 0) begin
          fail_count++;
          $display("%0t: byte %0d (last %0b) arrived with nothing expected",
                   $time, bytes_i.out_byte, bytes_i.last);
        end else begin
          want = charstring_q.pop_front();
          if (want.data !== bytes_i.out_byte) begin
            fail_count++;
            $display("%0t: out_byte mismatch: expected %0d, got %0d",
                     $time, want.data, bytes_i.out_byte);
          end
          if (want.last !== bytes_i.last) begin
            fail_count++;
            $display("%0t: last mismatch: expected %0b, got %0b", $time, want.last, bytes_i.last);
          end
        end
      end

      if (items_i.valid && items_i.ready)
        encode_item(items_i.op, items_i.value, items_i.kind, items_i.command);

      if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_PRECISION) begin
        if (pwrite) begin
          precision = pwdata[PREC_W-1:0];
        end else if (prdata !== PDATA_W'(precision)) begin
          fail_count++;
          $display("%0t: precision read-back mismatch: expected %0d, got %0d",
                   $time, precision, prdata);
        end
      end

      pending_o <= charstring_q.size();
    end
  end

endmodule

/* tb/type1_charstring_number_encoder_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the charstring number encoder: drives items, register accesses and
// output back-pressure, and gives the verdict from the scoreboard's failure count.
// Depends on t1cs_pkg, t1cs_if, the encoder RTL and t1cs_encoder_checker.
module type1_charstring_number_encoder_top_tb;
  import t1cs_pkg::*;

  localparam int FRAC           = 16;
  localparam int RESET_CYCLES   = 12;
  localparam int NUM_PHASES     = 9;
  localparam int PHASE_ITEMS    = 40;
  localparam int HOLDOFF_PHASE  = 2;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int TIMEOUT_NS     = 1_000_000;

  // kind codes the block does not name; they must behave as plain
  localparam logic [2:0]         KIND_SPARE_LO  = 3'd5;
  localparam logic [2:0]         KIND_SPARE_HI  = 3'd7;
  localparam logic [PADDR_W-1:0] PRECISION_ADDR = {REG_PRECISION, 2'b00};

  typedef struct {
    op_e                op;
    logic signed [31:0] value;
    logic [2:0]         kind;
    logic [6:0]         command;
  } item_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  int                 errors, pending;

  // hold-off request from the stimulus to the receiver process
  logic               holdoff_req = 1'b0;
  // sender burst state: beats left in this burst, and whether gaps are allowed
  int                 burst_left = 0;
  bit                 steady_sender = 1'b0;
  // coverage tallies for the closing summary
  int                 n_items = 0, n_commands = 0;
  int                 n_kind[8] = '{default: 0};

  t1cs_in_if  item_ch ();
  t1cs_out_if byte_ch ();

  type1_charstring_number_encoder_top #(
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (item_ch),
    .out_o  (byte_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  t1cs_encoder_checker #(
    .FRAC_BITS(FRAC)
  ) u_checker (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .items_i  (item_ch),
    .bytes_i  (byte_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .errors_o (errors),
    .pending_o(pending)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic item_t mk_item(op_e op, int value, logic [2:0] kind, logic [6:0] command);
    item_t it;
    it.op      = op;
    it.value   = value;
    it.kind    = kind;
    it.command = command;
    return it;
  endfunction

  // Random item. eff_prec is the precision the block actually applies, so that
  // exact multiples of one over it can be aimed at.
  function automatic item_t random_item(int eff_prec);
    item_t it;
    int    n;
    it.op      = ($urandom_range(0, 4) == 0) ? OP_COMMAND : OP_NUMBER;
    it.command = 7'($urandom);
    it.kind    = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI))
                                             : 3'($urandom_range(KIND_PLAIN, KIND_ABS_Y));
    case ($urandom_range(0, 5))
      0: it.value = $urandom;
      1: begin
        n        = $urandom_range(0, 240);
        it.value = (n - 120) <<< FRAC;
      end
      2: begin
        n        = $urandom_range(0, 2700);
        it.value = (n - 1350) <<< FRAC;
      end
      3: begin
        n        = $urandom_range(0, 100);
        it.value = ((n - 50) <<< FRAC) + $urandom_range(0, (1 <<< FRAC) - 1);
      end
      4: begin
        n        = $urandom_range(0, 4000);
        it.value = ((n - 2000) * (1 <<< FRAC)) / eff_prec;
      end
      default: begin
        case ($urandom_range(0, 5))
          0: it.value = 32'h7FFF_FFFF;
          1: it.value = 32'h8000_0000;
          2: it.value = 1 <<< (FRAC - 1);
          3: it.value = -(1 <<< (FRAC - 1));
          4: it.value = 1;
          default: it.value = -1;
        endcase
      end
    endcase
    return it;
  endfunction

  // Offer one item and hold it until taken. Bursts of random length with random
  // gaps between them, unless the sender is in a steady stretch.
  task automatic send_item(item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item_ch.valid   <= 1'b1;
    item_ch.op      <= it.op;
    item_ch.value   <= it.value;
    item_ch.kind    <= it.kind;
    item_ch.command <= it.command;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
    n_items++;
    if (it.op == OP_COMMAND) n_commands++;
    else n_kind[it.kind]++;
  endtask

  // Drop valid and wait until every expected byte has come back.
  task automatic drain_to_idle();
    item_ch.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
  endtask

  // One APB transfer: setup, access, then an idle phase with the bus released.
  task automatic apb_access(logic write, logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver: switch between stall patterns at random, always ready
  // among them; on request hold off for a long stretch so the block backs up.
  initial begin : receiver
    int mode, mode_left;
    mode_left     = 0;
    byte_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        byte_ch.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      case (mode)
        0: byte_ch.ready <= 1'b1;
        1: byte_ch.ready <= 1'($urandom_range(0, 1));
        2: byte_ch.ready <= ($urandom_range(0, 3) == 0);
        default: byte_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin : stimulus
    int prec_plan[NUM_PHASES];
    int eff;
    int waited;

    // Hold every input at a known value from time zero.
    rst_n           = 1'b0;
    item_ch.valid   = 1'b0;
    item_ch.op      = OP_NUMBER;
    item_ch.value   = '0;
    item_ch.kind    = KIND_PLAIN;
    item_ch.command = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Read back the reset value of precision before touching it.
    apb_access(1'b0, PRECISION_ADDR, '0);

    // Directed beats at the reset precision: every command range, every
    // integer form at its boundaries, both ends of the value range, halves
    // that round up, every coordinate kind and two of the unnamed kinds.
    send_item(mk_item(OP_COMMAND, $urandom, 3'($urandom), 7'd0));
    send_item(mk_item(OP_COMMAND, $urandom, 3'($urandom), 7'(ESC_DELTA - 1)));
    send_item(mk_item(OP_COMMAND, $urandom, 3'($urandom), 7'(ESC_DELTA)));
    send_item(mk_item(OP_COMMAND, 0, KIND_REL_X, 7'd95));
    send_item(mk_item(OP_COMMAND, -1, KIND_SPARE_HI, 7'd127));
    send_item(mk_item(OP_NUMBER, 0, KIND_PLAIN, 7'd127));
    send_item(mk_item(OP_NUMBER, SHORT_LIM <<< FRAC, KIND_PLAIN, 7'd0));
    send_item(mk_item(OP_NUMBER, (-SHORT_LIM) <<< FRAC, KIND_PLAIN, 7'd0));
    send_item(mk_item(OP_NUMBER, MID_OFF <<< FRAC, KIND_PLAIN, 7'd0));
    send_item(mk_item(OP_NUMBER, (-MID_OFF) <<< FRAC, KIND_PLAIN, 7'd0));
    send_item(mk_item(OP_NUMBER, MID_LIM <<< FRAC, KIND_PLAIN, 7'd0));
    send_item(mk_item(OP_NUMBER, (-MID_LIM) <<< FRAC, KIND_PLAIN, 7'd0));
    send_item(mk_item(OP_NUMBER, (MID_LIM + 1) <<< FRAC, KIND_PLAIN, 7'd0));
    send_item(mk_item(OP_NUMBER, (-MID_LIM - 1) <<< FRAC, KIND_PLAIN, 7'd0));
    send_item(mk_item(OP_NUMBER, 32'h7FFF_FFFF, KIND_PLAIN, 7'd0));
    send_item(mk_item(OP_NUMBER, 32'h8000_0000, KIND_PLAIN, 7'd0));
    send_item(mk_item(OP_NUMBER, 1 <<< (FRAC - 1), KIND_PLAIN, 7'd0));
    send_item(mk_item(OP_NUMBER, -(1 <<< (FRAC - 1)), KIND_PLAIN, 7'd0));
    send_item(mk_item(OP_NUMBER, 32'h0001_8000, KIND_REL_X, 7'd64));
    send_item(mk_item(OP_NUMBER, -32'sh0002_8000, KIND_REL_Y, 7'd0));
    send_item(mk_item(OP_NUMBER, 32'h0003_4000, KIND_ABS_X, 7'd0));
    send_item(mk_item(OP_NUMBER, -(1 <<< FRAC), KIND_ABS_Y, 7'd0));
    send_item(mk_item(OP_NUMBER, 1 <<< (FRAC - 1), KIND_REL_X, 7'd0));
    send_item(mk_item(OP_NUMBER, 32'h0001_2345, KIND_SPARE_LO, 7'd33));
    send_item(mk_item(OP_NUMBER, 32'h0001_2345, KIND_SPARE_HI, 7'd99));

    // Precision sweep: both ends of the legal range, values that fall back
    // to the default, one random setting and a return to the default.
    prec_plan = '{1, 107, 0, 3, 127, 108, 64, 0, 5};
    prec_plan[7] = $urandom_range(2, 106);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Only touch the register once the block has gone quiet.
      drain_to_idle();
      apb_access(1'b1, PRECISION_ADDR, PDATA_W'(prec_plan[ph]));
      apb_access(1'b0, PRECISION_ADDR, '0);
      eff = (prec_plan[ph] >= 1 && prec_plan[ph] <= PREC_MAX) ? prec_plan[ph] : PREC_DEFAULT;

      steady_sender = ($urandom_range(0, 2) == 0);
      if (ph == HOLDOFF_PHASE) begin
        // Stall the output for a long while and keep offering beats, so the
        // queue fills and the input stalls too.
        holdoff_req   = 1'b1;
        steady_sender = 1'b1;
      end

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_item(random_item(eff));
        // Now and then pause until everything has come out.
        if ($urandom_range(0, 59) == 0) drain_to_idle();
      end
    end

    // Let the last bytes out, then wait for anything stray.
    item_ch.valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (pending != 0) $display("%0t: %0d expected bytes never arrived", $time, pending);
    $display("Run covered %0d items: %0d commands, numbers plain %0d, relative %0d, absolute %0d,",
             n_items, n_commands, n_kind[KIND_PLAIN], n_kind[KIND_REL_X] + n_kind[KIND_REL_Y],
             n_kind[KIND_ABS_X] + n_kind[KIND_ABS_Y]);
    $display("unnamed kinds %0d, over %0d precision settings including out-of-range ones.",
             n_kind[KIND_SPARE_LO] + n_kind[6] + n_kind[KIND_SPARE_HI], NUM_PHASES);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("%0t: run timed out", $time);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* type1_charstring_number_encoder_top.f */
+incdir+design
design/t1cs_pkg.sv
design/t1cs_if.sv
design/t1cs_div.sv
design/t1cs_front.sv
design/t1cs_fifo.sv
design/t1cs_back.sv
design/type1_charstring_number_encoder_top.sv
design/t1cs_checker.sv
tb/t1cs_encoder_checker.sv
tb/type1_charstring_number_encoder_top_tb.sv
